### design/tssg_pkg.sv
// Package: shared types and defaults for the triangle span generator.
`timescale 1ns / 1ps
`default_nettype none
package tssg_pkg;
	localparam int TILE_ROWS_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;

	typedef enum logic [1:0] {
		K_POINT,
		K_FLATBOT,
		K_FLATTOP,
		K_SPLIT
	} kind_t;

	typedef struct packed {
		logic [9:0] x1;
		logic [9:0] x2;
		logic [9:0] x3;
		logic [5:0] y1;
		logic [5:0] y2;
		logic [5:0] y3;
		kind_t      kind;
	} tri_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_POINT,
		B_X4_GO,
		B_X4_WT,
		B_D0_GO,
		B_D0_WT,
		B_D1_GO,
		B_D1_WT,
		B_ROW
	} bstate_t;

	typedef struct packed {
		logic done;
		logic rnz;
	} div_rsp_t;
endpackage
`default_nettype wire

### design/tssg_front.sv
// Front: row clamp, vertex sort, classification and a two-entry triangle queue.
`timescale 1ns / 1ps
`default_nettype none
module tssg_front import tssg_pkg::*; #(
	parameter int TILE_ROWS = TILE_ROWS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [9:0] ax,
	input  wire logic [5:0] ay,
	input  wire logic [9:0] bx,
	input  wire logic [5:0] by,
	input  wire logic [9:0] cx,
	input  wire logic [5:0] cy,
	output logic            q_valid,
	output tri_t            q_data,
	input  wire logic       q_pop
);
	localparam logic [5:0] MAXROW = 6'(TILE_ROWS - 1);

	logic [5:0] ya, yb, yc;
	logic [9:0] sx1, sx2, sx3;
	logic [5:0] sy1, sy2, sy3;
	logic [9:0] tx;
	logic [5:0] ty;
	tri_t       tri_d;
	tri_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	always_comb begin
		tx = '0;
		ty = '0;
		ya = (ay > MAXROW) ? MAXROW : ay;
		yb = (by > MAXROW) ? MAXROW : by;
		yc = (cy > MAXROW) ? MAXROW : cy;
		sx1 = ax; sy1 = ya;
		sx2 = bx; sy2 = yb;
		sx3 = cx; sy3 = yc;
		if (sy1 > sy2) begin
			tx = sx1; sx1 = sx2; sx2 = tx;
			ty = sy1; sy1 = sy2; sy2 = ty;
		end
		if (sy2 > sy3) begin
			tx = sx2; sx2 = sx3; sx3 = tx;
			ty = sy2; sy2 = sy3; sy3 = ty;
		end
		if (sy1 > sy2) begin
			tx = sx1; sx1 = sx2; sx2 = tx;
			ty = sy1; sy1 = sy2; sy2 = ty;
		end
		tri_d.x1 = sx1; tri_d.x2 = sx2; tri_d.x3 = sx3;
		tri_d.y1 = sy1; tri_d.y2 = sy2; tri_d.y3 = sy3;
		if (sy2 == sy3) begin
			tri_d.kind = (sy1 == sy2) ? K_POINT : K_FLATBOT;
		end else begin
			tri_d.kind = (sy1 == sy2) ? K_FLATTOP : K_SPLIT;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= tri_d;
	end
endmodule
`default_nettype wire

### design/tssg_div.sv
// Divider: restoring unsigned division by a 6-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tssg_div import tssg_pkg::*; #(
	parameter int NUM_W = FRAC_BITS_DEF + 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [5:0]       den,
	output logic      [NUM_W-1:0] quo,
	output div_rsp_t              rsp
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [5:0]       rem_q, den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [6:0]       t;
	logic             bit_d;
	logic [6:0]       rem_d;

	always_comb begin
		t     = {rem_q, num_q[NUM_W-1]};
		bit_d = (t >= {1'b0, den_q});
		rem_d = bit_d ? (t - {1'b0, den_q}) : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], bit_d};
			rem_q <= rem_d[5:0];
		end
	end

	assign quo      = num_q;
	assign rsp.done = done_q;
	assign rsp.rnz  = (rem_q != 6'd0);
endmodule
`default_nettype wire

### design/tssg_back.sv
// Back: slope setup, edge stepping per scanline and the span output register.
`timescale 1ns / 1ps
`default_nettype none
module tssg_back import tssg_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  tri_t            q_data,
	output logic            q_pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [5:0]      row_y,
	output logic [9:0]      span_left,
	output logic [9:0]      span_right,
	output logic            last_span
);
	localparam int NUM_W = FRAC_BITS + 10;
	localparam int SL_W  = NUM_W + 1;
	localparam int ACC_W = FRAC_BITS + 13;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

	function automatic logic [9:0] pix(input logic signed [ACC_W-1:0] a);
		logic signed [12:0] ip;
		ip = a[ACC_W-1:FRAC_BITS];
		if (ip < 0) return 10'd0;
		if (ip > 13'sd1023) return 10'd1023;
		return ip[9:0];
	endfunction

	bstate_t st_q, st_d;
	tri_t    tri_q;
	logic [9:0]  ex0_q, ex1_q;
	logic signed [10:0] dx0_q, dx1_q;
	logic [5:0]  h_q, ybase_q, k_q;
	logic        lower_q;
	logic signed [SL_W-1:0]  sl0_q, sl1_q;
	logic signed [ACC_W-1:0] acc0_q, acc1_q;
	logic        out_valid_q, last_q;
	logic [5:0]  row_q;
	logic [9:0]  left_q, right_q;

	logic             div_start;
	logic [NUM_W-1:0] div_num, div_quo;
	logic [5:0]       div_den;
	div_rsp_t         div_rsp;

	logic out_load, emit, skip, upper_split, at_end;
	logic signed [10:0] dxs, d31;
	logic [9:0]  absdx;
	logic signed [16:0] prod;
	logic [16:0] prod_mag;
	logic signed [SL_W-1:0] sl;
	logic signed [11:0] x4v;
	logic [9:0]  x4, p0, p1, lo, hi, slo, shi;
	logic [5:0]  row_d;
	logic [9:0]  left_d, right_d;
	logic        last_d;

	tssg_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.rsp    (div_rsp)
	);

	always_comb begin
		d31  = $signed({1'b0, tri_q.x3}) - $signed({1'b0, tri_q.x1});
		prod = $signed({11'b0, tri_q.y2 - tri_q.y1}) * $signed({{6{d31[10]}}, d31});
		prod_mag = prod[16] ? 17'(-prod) : 17'(prod);
		dxs   = (st_q inside {B_D0_GO, B_D0_WT}) ? dx0_q : dx1_q;
		absdx = dxs[10] ? 10'(-dxs) : dxs[9:0];
		if (st_q == B_X4_GO) begin
			div_num = NUM_W'(prod_mag[15:0]);
			div_den = tri_q.y3 - tri_q.y1;
		end else begin
			div_num = {absdx, {FRAC_BITS{1'b0}}};
			div_den = h_q;
		end
		sl = dxs[10] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		if (d31[10]) begin
			x4v = $signed({2'b0, tri_q.x1}) - $signed({1'b0, div_quo[10:0]})
				- $signed({11'b0, div_rsp.rnz});
		end else begin
			x4v = $signed({2'b0, tri_q.x1}) + $signed({1'b0, div_quo[10:0]});
		end
		x4 = x4v[9:0];
		p0 = pix(acc0_q);
		p1 = pix(acc1_q);
		lo = (p0 < p1) ? p0 : p1;
		hi = (p0 < p1) ? p1 : p0;
		slo = (tri_q.x2 < ex1_q) ? tri_q.x2 : ex1_q;
		shi = (tri_q.x2 < ex1_q) ? ex1_q : tri_q.x2;
		if (lo < slo) slo = lo;
		if (hi > shi) shi = hi;
	end

	assign out_load    = !out_valid_q || !out_stall;
	assign upper_split = (tri_q.kind == K_SPLIT) && !lower_q;
	assign at_end      = (k_q == h_q);

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					case (q_data.kind)
						K_POINT: st_d = B_POINT;
						K_SPLIT: st_d = B_X4_GO;
						default: st_d = B_D0_GO;
					endcase
				end
			end
			B_POINT: if (out_load) st_d = B_IDLE;
			B_X4_GO: st_d = B_X4_WT;
			B_X4_WT: if (div_rsp.done) st_d = B_D0_GO;
			B_D0_GO: st_d = B_D0_WT;
			B_D0_WT: if (div_rsp.done) st_d = B_D1_GO;
			B_D1_GO: st_d = B_D1_WT;
			B_D1_WT: if (div_rsp.done) st_d = B_ROW;
			B_ROW: begin
				if (emit && at_end) st_d = upper_split ? B_D0_GO : B_IDLE;
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (st_q == B_IDLE) && q_valid;
		div_start = (st_q inside {B_X4_GO, B_D0_GO, B_D1_GO});
		emit      = 1'b0;
		skip      = 1'b0;
		row_d     = ybase_q + k_q;
		left_d    = lo;
		right_d   = hi;
		last_d    = at_end && !upper_split;
		case (st_q)
			B_POINT: begin
				emit    = out_load;
				row_d   = tri_q.y1;
				left_d  = tri_q.x1;
				right_d = tri_q.x1;
				last_d  = 1'b1;
			end
			B_ROW: begin
				if (lower_q && k_q == 6'd0) begin
					skip = 1'b1;
				end else begin
					emit = out_load;
					if (upper_split && at_end) begin
						left_d  = slo;
						right_d = shi;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tri_q   <= q_data;
			lower_q <= 1'b0;
			k_q     <= 6'd0;
			ybase_q <= q_data.y1;
			ex0_q   <= q_data.x1;
			case (q_data.kind)
				K_FLATTOP: begin
					dx0_q <= $signed({1'b0, q_data.x3}) - $signed({1'b0, q_data.x1});
					ex1_q <= q_data.x2;
					dx1_q <= $signed({1'b0, q_data.x3}) - $signed({1'b0, q_data.x2});
					h_q   <= q_data.y3 - q_data.y1;
				end
				default: begin
					dx0_q <= $signed({1'b0, q_data.x2}) - $signed({1'b0, q_data.x1});
					ex1_q <= q_data.x1;
					dx1_q <= $signed({1'b0, q_data.x3}) - $signed({1'b0, q_data.x1});
					h_q   <= q_data.y2 - q_data.y1;
				end
			endcase
		end
		if (st_q == B_X4_WT && div_rsp.done) begin
			ex1_q <= x4;
			dx1_q <= $signed({1'b0, x4}) - $signed({1'b0, tri_q.x1});
		end
		if (st_q == B_D0_WT && div_rsp.done) sl0_q <= sl;
		if (st_q == B_D1_WT && div_rsp.done) begin
			sl1_q  <= sl;
			acc0_q <= $signed({3'b000, ex0_q, {FRAC_BITS{1'b0}}}) + HALF;
			if (upper_split)
				acc1_q <= $signed({3'b000, ex0_q, {FRAC_BITS{1'b0}}}) + HALF;
			else
				acc1_q <= $signed({3'b000, ex1_q, {FRAC_BITS{1'b0}}}) + HALF;
			k_q    <= 6'd0;
		end
		if (st_q == B_ROW) begin
			if (skip || (emit && !at_end)) begin
				acc0_q <= acc0_q + {{2{sl0_q[SL_W-1]}}, sl0_q};
				acc1_q <= acc1_q + {{2{sl1_q[SL_W-1]}}, sl1_q};
				k_q    <= k_q + 6'd1;
			end else if (emit && upper_split) begin
				lower_q <= 1'b1;
				ybase_q <= tri_q.y2;
				ex0_q   <= tri_q.x2;
				dx0_q   <= $signed({1'b0, tri_q.x3}) - $signed({1'b0, tri_q.x2});
				dx1_q   <= $signed({1'b0, tri_q.x3}) - $signed({1'b0, ex1_q});
				h_q     <= tri_q.y3 - tri_q.y2;
			end
		end
		if (emit) begin
			row_q   <= row_d;
			left_q  <= left_d;
			right_q <= right_d;
			last_q  <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_y      = row_q;
	assign span_left  = left_q;
	assign span_right = right_q;
	assign last_span  = last_q;
endmodule
`default_nettype wire

### design/triangle_scanline_span_generator.sv
// Top level: triangle scanline span generator, front queue feeding the span back end.
// Setup: the first span waits for two slope divisions on the shared bit-serial divider,
//   a split triangle for one more before them, a point triangle for none.
// Throughput: one span per cycle while rows run and out_stall is low; a split
//   triangle pays two more slope divisions at the middle row.
// Reset: arst_n clears the queue, sequencer and output valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module triangle_scanline_span_generator import tssg_pkg::*; #(
	parameter int TILE_ROWS = TILE_ROWS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [9:0] ax,
	input  wire logic [5:0] ay,
	input  wire logic [9:0] bx,
	input  wire logic [5:0] by,
	input  wire logic [9:0] cx,
	input  wire logic [5:0] cy,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [5:0]      row_y,
	output logic [9:0]      span_left,
	output logic [9:0]      span_right,
	output logic            last_span
);
	logic q_valid, q_pop;
	tri_t q_data;

	tssg_front #(.TILE_ROWS(TILE_ROWS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by       (by),
		.cx       (cx),
		.cy       (cy),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop)
	);

	tssg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_y      (row_y),
		.span_left  (span_left),
		.span_right (span_right),
		.last_span  (last_span)
	);
endmodule
`default_nettype wire

### design/tssg_checker.sv
// Checker: port-level assertions on the span output, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tssg_checker import tssg_pkg::*; #(
	parameter int TILE_ROWS = TILE_ROWS_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [5:0] row_y,
	input wire logic [9:0] span_left,
	input wire logic [9:0] span_right,
	input wire logic       last_span
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("span word dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({row_y, span_left, span_right, last_span}))
		else $error("stalled span word changed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> span_left <= span_right)
		else $error("span left beyond right");

	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_y <= 6'(TILE_ROWS - 1))
		else $error("span row outside tile");
endmodule

bind triangle_scanline_span_generator tssg_checker #(.TILE_ROWS(TILE_ROWS)) u_chk (.*);
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the triangle scanline span generator.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import tssg_pkg::*;

	typedef struct packed {
		logic [5:0] y;
		logic [9:0] l;
		logic [9:0] r;
		logic       last;
	} span_t;

	class span_board;
		span_t pending[$];
		int errors;
		int spans;

		function longint fdiv(longint a, longint d);
			longint q;
			q = a / d;
			if ((a % d) != 0 && a < 0) q--;
			return q;
		endfunction

		function longint slope(longint dx, longint dy);
			return (dx * (longint'(1) << FRAC_BITS_DEF)) / dy;
		endfunction

		function longint pix(longint x0, longint s, longint k);
			longint one, p;
			one = longint'(1) << FRAC_BITS_DEF;
			p = fdiv(x0 * one + k * s + one / 2, one);
			if (p < 0) p = 0;
			if (p > 1023) p = 1023;
			return p;
		endfunction

		function void push(longint y, longint a, longint b);
			span_t s;
			s.y = y[5:0];
			s.l = (a < b) ? a[9:0] : b[9:0];
			s.r = (a < b) ? b[9:0] : a[9:0];
			s.last = 1'b0;
			pending.push_back(s);
		endfunction

		function void note_triangle(logic [9:0] ax, logic [5:0] ay, logic [9:0] bx,
				logic [5:0] by, logic [9:0] cx, logic [5:0] cy);
			longint x1, y1, x2, y2, x3, y3, t, h, h1, h2, x4, s1, s2, s3, s4, pa, pb, lo, hi;
			span_t s;
			x1 = ax; y1 = ay; x2 = bx; y2 = by; x3 = cx; y3 = cy;
			if (y1 > y2) begin t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t; end
			if (y2 > y3) begin t = x2; x2 = x3; x3 = t; t = y2; y2 = y3; y3 = t; end
			if (y1 > y2) begin t = x1; x1 = x2; x2 = t; t = y1; y1 = y2; y2 = t; end
			if (y2 == y3 && y1 == y2) begin
				push(y1, x1, x1);
			end else if (y2 == y3) begin
				h = y2 - y1;
				s1 = slope(x2 - x1, h);
				s2 = slope(x3 - x1, h);
				for (longint k = 0; k <= h; k++)
					push(y1 + k, pix(x1, s1, k), pix(x1, s2, k));
			end else if (y1 == y2) begin
				h = y3 - y1;
				s1 = slope(x3 - x1, h);
				s2 = slope(x3 - x2, h);
				for (longint k = 0; k <= h; k++)
					push(y1 + k, pix(x1, s1, k), pix(x2, s2, k));
			end else begin
				h1 = y2 - y1;
				h2 = y3 - y2;
				x4 = x1 + fdiv(h1 * (x3 - x1), y3 - y1);
				s1 = slope(x2 - x1, h1);
				s2 = slope(x4 - x1, h1);
				s3 = slope(x3 - x2, h2);
				s4 = slope(x3 - x4, h2);
				for (longint k = 0; k < h1; k++)
					push(y1 + k, pix(x1, s1, k), pix(x1, s2, k));
				pa = pix(x1, s1, h1);
				pb = pix(x1, s2, h1);
				lo = (x2 < x4) ? x2 : x4;
				hi = (x2 < x4) ? x4 : x2;
				if (pa < lo) lo = pa;
				if (pb < lo) lo = pb;
				if (pa > hi) hi = pa;
				if (pb > hi) hi = pb;
				push(y2, lo, hi);
				for (longint k = 1; k <= h2; k++)
					push(y2 + k, pix(x2, s3, k), pix(x4, s4, k));
			end
			s = pending.pop_back();
			s.last = 1'b1;
			pending.push_back(s);
		endfunction

		function void check_span(span_t got);
			span_t e;
			spans++;
			if (pending.size() == 0) begin
				$error("unexpected span row=%0d", got.y);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.y !== e.y) begin
				$error("row_y expected %0d actual %0d", e.y, got.y); errors++;
			end
			if (got.l !== e.l) begin
				$error("span_left expected %0d actual %0d", e.l, got.l); errors++;
			end
			if (got.r !== e.r) begin
				$error("span_right expected %0d actual %0d", e.r, got.r); errors++;
			end
			if (got.last !== e.last) begin
				$error("last_span expected %0d actual %0d", e.last, got.last); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [9:0] ax = '0, bx = '0, cx = '0;
	logic [5:0] ay = '0, by = '0, cy = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] row_y;
	logic [9:0] span_left, span_right;
	logic last_span;

	span_board board = new();
	bit calm = 1'b0;
	int triangles = 0;
	longint cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	triangle_scanline_span_generator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy),
		.out_valid(out_valid), .out_stall(out_stall),
		.row_y(row_y), .span_left(span_left), .span_right(span_right),
		.last_span(last_span)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_span({row_y, span_left, span_right, last_span});
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (calm || !arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_triangle(logic [9:0] x0, logic [5:0] y0, logic [9:0] x1,
			logic [5:0] y1, logic [9:0] x2, logic [5:0] y2);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		ax <= x0; ay <= y0; bx <= x1; by <= y1; cx <= x2; cy <= y2;
		do @(posedge clk); while (in_stall);
		board.note_triangle(x0, y0, x1, y1, x2, y2);
		triangles++;
	endtask

	function automatic logic [5:0] near_row(logic [5:0] base);
		int v;
		v = base + $urandom_range(0, 12);
		return (v > 63) ? 6'd63 : v[5:0];
	endfunction

	initial begin
		logic [5:0] r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_triangle(10'd5, 6'd7, 10'd900, 6'd7, 10'd1023, 6'd7);
		send_triangle(10'd0, 6'd0, 10'd1023, 6'd63, 10'd512, 6'd30);
		send_triangle(10'd1023, 6'd63, 10'd0, 6'd0, 10'd0, 6'd63);
		send_triangle(10'd100, 6'd10, 10'd50, 6'd20, 10'd150, 6'd20);
		send_triangle(10'd100, 6'd5, 10'd300, 6'd5, 10'd200, 6'd25);
		send_triangle(10'd1023, 6'd0, 10'd0, 6'd1, 10'd1023, 6'd2);
		send_triangle(10'd0, 6'd40, 10'd1023, 6'd41, 10'd0, 6'd42);
		send_triangle(10'd341, 6'd20, 10'd682, 6'd21, 10'd1, 6'd23);
		send_triangle(10'd3, 6'd12, 10'd1, 6'd13, 10'd0, 6'd19);
		send_triangle(10'd0, 6'd62, 10'd1023, 6'd63, 10'd7, 6'd62);
		send_triangle(10'd1022, 6'd0, 10'd1, 6'd0, 10'd2, 6'd1);
		send_triangle(10'd600, 6'd63, 10'd600, 6'd0, 10'd600, 6'd31);
		for (int i = 0; i < 150; i++) begin
			if (i == 120) calm = 1'b1;
			r = 6'($urandom_range(0, 63));
			case ($urandom_range(0, 5))
				0: send_triangle(10'($urandom), 6'($urandom), 10'($urandom), 6'($urandom),
					10'($urandom), 6'($urandom));
				1: send_triangle(10'($urandom), r, 10'($urandom), r, 10'($urandom),
					near_row(r));
				2: send_triangle(10'($urandom), near_row(r), 10'($urandom), r,
					10'($urandom), near_row(r));
				3: send_triangle(10'($urandom), r, 10'($urandom), r, 10'($urandom), r);
				default: send_triangle(10'($urandom), r, 10'($urandom), near_row(r),
					10'($urandom), near_row(r));
			endcase
		end
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Sent %0d triangles, checked %0d spans over point, flat and split shapes.",
			triangles, board.spans);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
